[hw/rtl/delimited_frame_receiver_assert.svh]
// assertion macros included by the frame receiver top
`ifndef DELIMITED_FRAME_RECEIVER_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication, checked out of reset
`define DFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

[hw/rtl/dfr_pkg.sv]
// types and constants of the delimited frame receiver
package dfr_pkg;

  localparam int unsigned CountBitsDef = 12;
  localparam int unsigned MaxPayloadW  = 12;
  localparam int unsigned ByteCountW   = 12;
  localparam logic [MaxPayloadW-1:0] MaxPayloadRst = '1;

  localparam logic [7:0] ChBang = 8'h21;
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;

  // result queue depth and level width
  localparam int unsigned ResDepth = 8;
  localparam int unsigned ResAddrW = $clog2(ResDepth);
  localparam int unsigned LevelW   = ResAddrW + 1;

  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindDone  = 2'd1,
    KindOver  = 2'd2,
    KindNoEnd = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            payload;
    logic [ByteCountW-1:0] byte_count;
    logic                  last;
  } res_t;

  // results produced by one item, n of them valid (0 to 2)
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

[hw/rtl/dfr_core.sv]
// deframing state machine: one registered byte in, up to two results out
module dfr_core import dfr_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [7:0]             byte_i,
  input  logic [MaxPayloadW-1:0] max_payload_i,
  output step_t                  step_o
);

  typedef enum logic [1:0] {
    PhHunt  = 2'd0,
    PhStart = 2'd1,
    PhRecv  = 2'd2,
    PhBang  = 2'd3
  } phase_e;

  localparam int unsigned CmpW =
    ((COUNT_BITS > MaxPayloadW) ? COUNT_BITS : MaxPayloadW) + 1;

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] lim;
  logic [CmpW-1:0]       cap_w, max_w;
  logic [COUNT_BITS:0]   count_inc1;
  logic                  room_one, room_pair;
  logic [ByteCountW-1:0] count_out;

  // limit is max_payload capped at the counter's full scale
  assign cap_w = CmpW'((1 << COUNT_BITS) - 1);
  assign max_w = CmpW'(max_payload_i);
  assign lim   = (max_w < cap_w) ? COUNT_BITS'(max_payload_i) : {COUNT_BITS{1'b1}};

  assign count_inc1 = {1'b0, count_q} + (COUNT_BITS+1)'(1);
  assign room_one   = count_q < lim;
  assign room_pair  = count_inc1 < {1'b0, lim};
  assign count_out  = ByteCountW'(count_q);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    step_o  = '0;
    if (valid_i) begin
      case (phase_q)
        PhHunt: begin
          if (byte_i == ChBang) phase_d = PhStart;
        end
        PhStart: begin
          if (byte_i == ChAmp) begin
            phase_d = PhRecv;
            count_d = '0;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhRecv: begin
          if (byte_i == ChBang) begin
            phase_d = PhBang;
          end else if (room_one) begin
            step_o.n          = 2'd1;
            step_o.r0.kind    = KindData;
            step_o.r0.payload = byte_i;
            step_o.r0.last    = 1'b1;
            count_d           = count_q + COUNT_BITS'(1);
          end else begin
            step_o.n             = 2'd1;
            step_o.r0.kind       = KindOver;
            step_o.r0.byte_count = count_out;
            step_o.r0.last       = 1'b1;
            phase_d              = PhHunt;
            count_d              = '0;
          end
        end
        PhBang: begin
          if (byte_i == ChHash) begin
            step_o.n             = 2'd1;
            step_o.r0.kind       = KindDone;
            step_o.r0.byte_count = count_out;
            step_o.r0.last       = 1'b1;
            phase_d              = PhHunt;
            count_d              = '0;
          end else if (room_pair) begin
            // kept '!' and the byte after it
            step_o.n          = 2'd2;
            step_o.r0.kind    = KindData;
            step_o.r0.payload = ChBang;
            step_o.r1.kind    = KindData;
            step_o.r1.payload = byte_i;
            step_o.r1.last    = 1'b1;
            count_d           = count_q + COUNT_BITS'(2);
            phase_d           = PhRecv;
          end else begin
            step_o.n             = 2'd1;
            step_o.r0.kind       = KindNoEnd;
            step_o.r0.byte_count = count_out;
            step_o.r0.last       = 1'b1;
            phase_d              = PhHunt;
            count_d              = '0;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

[hw/rtl/dfr_res_fifo.sv]
// result queue: takes up to two results a cycle, hands out one
module dfr_res_fifo import dfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  step_t             step_i,
  input  logic              pop_i,
  output res_t              head_o,
  output logic [LevelW-1:0] level_o
);

  res_t                mem_q [ResDepth];
  logic [ResAddrW-1:0] wr_q, rd_q;
  logic [ResAddrW-1:0] wr_next;
  logic [LevelW-1:0]   level_q;
  logic                pop_ok;

  assign wr_next = wr_q + ResAddrW'(1);
  assign pop_ok  = pop_i && (level_q != '0);
  assign head_o  = mem_q[rd_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i) begin
    if (step_i.n != 2'd0) mem_q[wr_q] <= step_i.r0;
    if (step_i.n == 2'd2) mem_q[wr_next] <= step_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + ResAddrW'(step_i.n);
      if (pop_ok) rd_q <= rd_q + ResAddrW'(1);
      level_q <= level_q + LevelW'(step_i.n) - LevelW'(pop_ok);
    end
  end

endmodule

[hw/rtl/delimited_frame_receiver.sv]
// Delimited frame receiver: hunts for the start pair '!' '&', passes payload
// bytes until '!' '#', keeps an inner '!' plus the byte after it as two payload
// bytes, and reports completion, overflow past max_payload, or no room for a
// kept pair, each with the frame's byte count. One byte is accepted per clock
// while in_stall_o is low; it is registered, then its results are queued. The
// single result port hands out one result per cycle while out_stall_i is low,
// so an eight-entry result queue absorbs kept '!' pairs (two results); input
// stall rises when the queue cannot hold the worst case of the bytes in flight.
// max_payload is written through the config channel, which is always ready, and
// should only be changed while no frame traffic is in flight.
module delimited_frame_receiver import dfr_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [MaxPayloadW-1:0] cfg_max_payload_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             in_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             payload_o,
  output logic [ByteCountW-1:0]  byte_count_o,
  output logic                   last_o
);

  `include "delimited_frame_receiver_assert.svh"

  logic [MaxPayloadW-1:0] max_payload_q;
  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic                   in_take;
  step_t                  step;
  res_t                   head;
  logic [LevelW-1:0]      level;
  logic [LevelW:0]        level_ext, pend_room;

  assign cfg_ready_o = 1'b1;

  // reserve two queue slots per byte not yet pushed
  assign level_ext  = (LevelW+1)'(level);
  assign pend_room  = in_valid_q ? (LevelW+1)'(2) : '0;
  assign in_stall_o = (level_ext + pend_room) > (LevelW+1)'(ResDepth - 2);
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadRst;
      in_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) max_payload_q <= cfg_max_payload_i;
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= in_byte_i;
  end

  dfr_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_q),
    .byte_i       (in_byte_q),
    .max_payload_i(max_payload_q),
    .step_o       (step)
  );

  dfr_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pop_i  (out_valid_o && !out_stall_i),
    .head_o (head),
    .level_o(level)
  );

  assign out_valid_o  = (level != '0);
  assign kind_o       = head.kind;
  assign payload_o    = head.payload;
  assign byte_count_o = head.byte_count;
  assign last_o       = head.last;

  `DFR_ASSERT_IMPL(a_level_bound, 1'b1, level <= LevelW'(ResDepth))
  `DFR_ASSERT_IMPL(a_report_shape, out_valid_o && (kind_o != KindData),
                   (payload_o == 8'd0) && last_o)
  `DFR_ASSERT_IMPL(a_data_no_count, out_valid_o && (kind_o == KindData),
                   byte_count_o == '0)
  `DFR_ASSERT_NEXT(a_taken_reaches_core, in_take, in_valid_q)

endmodule
